### src/upgma_pkg.sv
// Shared constants, types and the triangular pair-slot function for the UPGMA engine.
// Used by upgma_cluster_engine; no dependencies.
package upgma_pkg;

   localparam int MAX_TAXA    = 32;
   localparam int DIST_WIDTH  = 32;
   localparam int NODE_SLOTS  = 2 * MAX_TAXA - 2;
   localparam int STORE_DEPTH = NODE_SLOTS * (NODE_SLOTS - 1) / 2;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int NODE_W      = 6;
   localparam int IDX_W       = 5;
   localparam int TAXA_W      = 6;
   localparam int SIZE_W      = 6;
   localparam int SUM_W       = SIZE_W + 1;
   localparam int NUM_W       = SIZE_W + DIST_WIDTH + 1;
   localparam int DIV_CW      = $clog2(NUM_W + 1);
   localparam int NODE_DW     = DIST_WIDTH + SIZE_W;

   typedef logic [NODE_W-1:0]     node_type;
   typedef logic [DIST_WIDTH-1:0] dist_type;
   typedef logic [STORE_AW-1:0]   slot_type;
   typedef logic [SIZE_W-1:0]     size_type;

   // Slot of the unordered pair (a, b) in the lower-triangle store: hi*(hi-1)/2 + lo.
   function automatic slot_type pair_slot(node_type a, node_type b);
      node_type              lo;
      node_type              hi;
      logic [2*NODE_W-1:0]   prod;
      lo   = (a < b) ? a : b;
      hi   = (a < b) ? b : a;
      prod = {{NODE_W{1'b0}}, hi} * ({{NODE_W{1'b0}}, hi} - {{(2*NODE_W-1){1'b0}}, 1'b1});
      return slot_type'(prod >> 1) + slot_type'(lo);
   endfunction

endpackage

### src/upgma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module upgma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### src/upgma_cluster_engine.sv
// UPGMA hierarchical clustering engine: matrix load, sequenced merge rounds, result strobe.
// Depends on upgma_pkg and upgma_ram.
//
// Usage: write taxa_count (n) through csr_wr_en/csr_wr_data while the engine is idle.
// Load the upper triangle of the distance matrix one entry per transaction: a
// transaction is accepted when start is high and busy is low. Entries with
// row >= col or col >= n are dropped. The entry with req_last_entry set starts
// clustering; busy then stays high until the root join has been reported.
// Loading accepts one entry per cycle while the engine is idle. Each merge round w
// scans all pairs below w, one pair per cycle, through the single distance-RAM read
// port, reads the two child records (ST_RD_U, ST_RD_V, ST_RD_W), then visits every
// k below w: an inactive or just-merged k is skipped, and each remaining active node
// k is updated through the shared 6x32 multiplier and the one-bit-per-cycle restoring
// divider. The round then closes its loop and ends in the commit.
// Each join is reported on the rsp_ ports for one cycle with rsp_valid high;
// the receiver cannot stall, so results are never held. The root join carries
// rsp_last_merge and busy drops in the same cycle. Reset returns the engine to
// idle with taxa_count = 2 and no active nodes; stored distances are not cleared.
module upgma_cluster_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [upgma_pkg::IDX_W-1:0]          req_row_index,
   input  logic [upgma_pkg::IDX_W-1:0]          req_col_index,
   input  logic [upgma_pkg::DIST_WIDTH-1:0]     req_distance,
   input  logic                                 req_last_entry,
   input  logic                                 csr_wr_en,
   input  logic [upgma_pkg::TAXA_W-1:0]         csr_wr_data,
   output logic                                 rsp_valid,
   output logic [upgma_pkg::NODE_W-1:0]         rsp_left_node,
   output logic [upgma_pkg::NODE_W-1:0]         rsp_right_node,
   output logic [upgma_pkg::NODE_W-1:0]         rsp_parent_node,
   output logic [upgma_pkg::DIST_WIDTH-1:0]     rsp_left_branch,
   output logic [upgma_pkg::DIST_WIDTH-1:0]     rsp_right_branch,
   output logic                                 rsp_last_merge
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_RD_U, ST_RD_V, ST_RD_W, ST_CHK, ST_RDB,
      ST_MULB, ST_DIV, ST_WR, ST_COMMIT, ST_FIN_SCAN, ST_FIN_RD, ST_FIN_RDV, ST_FIN_EMIT
   } state_type;

   state_type                          state_ff;
   logic [upgma_pkg::TAXA_W-1:0]       taxa_ff;
   upgma_pkg::node_type                n_ff, top_ff, w_ff, i_ff, j_ff, k_ff;
   upgma_pkg::node_type                u_ff, v_ff, pu_ff, pv_ff, nidx_ff;
   upgma_pkg::dist_type                best_ff, hu_ff, hv_ff;
   logic                               found_ff, pend_ff, seen_ff;
   logic [upgma_pkg::NODE_SLOTS-1:0]   act_ff;
   upgma_pkg::size_type                su_ff, sv_ff;
   logic [upgma_pkg::NUM_W-1:0]        acc_ff;
   logic [upgma_pkg::SUM_W-1:0]        rem_ff;
   logic [upgma_pkg::DIV_CW-1:0]       div_cnt_ff;

   logic                               rsp_valid_ff, rsp_last_ff;
   upgma_pkg::node_type                rsp_left_ff, rsp_right_ff, rsp_parent_ff;
   upgma_pkg::dist_type                rsp_lbr_ff, rsp_rbr_ff;

   // RAM ports
   logic                               dist_wr_en;
   upgma_pkg::slot_type                dist_wr_addr, dist_rd_addr;
   upgma_pkg::dist_type                dist_wr_data, dist_rd_data;
   logic                               node_wr_en;
   upgma_pkg::node_type                node_rd_addr;
   logic [upgma_pkg::NODE_DW-1:0]      node_wr_data, node_rd_data;

   upgma_pkg::node_type                n_cfg;
   logic [upgma_pkg::NODE_W:0]         top_cfg;
   logic                               accept;
   upgma_pkg::dist_type                node_h, hw, lbr, rbr, hv_fin, lbr_fin, rbr_fin;
   upgma_pkg::size_type                node_s, mul_s;
   logic [upgma_pkg::SUM_W-1:0]        sw;
   logic [upgma_pkg::NUM_W-1:0]        product;
   logic [upgma_pkg::SUM_W:0]          div_r2;
   logic                               div_bit;
   logic                               cand_better;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      if (taxa_ff < upgma_pkg::TAXA_W'(2)) begin
         n_cfg = upgma_pkg::NODE_W'(2);
      end else if (taxa_ff > upgma_pkg::TAXA_W'(upgma_pkg::MAX_TAXA)) begin
         n_cfg = upgma_pkg::NODE_W'(upgma_pkg::MAX_TAXA);
      end else begin
         n_cfg = upgma_pkg::NODE_W'(taxa_ff);
      end
      top_cfg = {n_cfg, 1'b0} - (upgma_pkg::NODE_W + 1)'(2);
   end

   // Leaves have height zero and size one; their node-RAM entries are never written.
   always_comb begin
      if (nidx_ff < n_ff) begin
         node_h = '0;
         node_s = upgma_pkg::SIZE_W'(1);
      end else begin
         node_h = node_rd_data[upgma_pkg::NODE_DW-1:upgma_pkg::SIZE_W];
         node_s = node_rd_data[upgma_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      hw      = best_ff >> 1;
      lbr     = (hw > hu_ff) ? hw - hu_ff : '0;
      rbr     = (hw > hv_ff) ? hw - hv_ff : '0;
      hv_fin  = node_h;
      lbr_fin = (hw > hu_ff) ? hw - hu_ff : '0;
      rbr_fin = (hw > hv_fin) ? hw - hv_fin : '0;
      sw      = {1'b0, su_ff} + {1'b0, sv_ff};
      mul_s   = (state_ff == ST_RDB) ? su_ff : sv_ff;
      product = upgma_pkg::NUM_W'(mul_s) * upgma_pkg::NUM_W'(dist_rd_data);
      div_r2  = {rem_ff, acc_ff[upgma_pkg::NUM_W-1]};
      div_bit = (div_r2 >= {1'b0, sw});
      cand_better = pend_ff && (!found_ff || (dist_rd_data < best_ff));
   end

   always_comb begin
      dist_wr_en   = 1'b0;
      dist_wr_addr = upgma_pkg::pair_slot(upgma_pkg::NODE_W'(req_row_index),
                                          upgma_pkg::NODE_W'(req_col_index));
      dist_wr_data = req_distance;
      if (accept && (req_row_index < req_col_index)
          && (upgma_pkg::NODE_W'(req_col_index) < n_cfg)) begin
         dist_wr_en = 1'b1;
      end else if (state_ff == ST_WR) begin
         dist_wr_en   = 1'b1;
         dist_wr_addr = upgma_pkg::pair_slot(k_ff, w_ff);
         dist_wr_data = acc_ff[upgma_pkg::DIST_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_SCAN:   dist_rd_addr = upgma_pkg::pair_slot(i_ff, j_ff);
         ST_CHK:    dist_rd_addr = upgma_pkg::pair_slot(u_ff, k_ff);
         ST_RDB:    dist_rd_addr = upgma_pkg::pair_slot(v_ff, k_ff);
         default:   dist_rd_addr = upgma_pkg::pair_slot(u_ff, v_ff);
      endcase
      unique case (state_ff)
         ST_RD_V, ST_FIN_RDV: node_rd_addr = v_ff;
         default:             node_rd_addr = u_ff;
      endcase
      node_wr_en   = (state_ff == ST_COMMIT);
      node_wr_data = {hw, upgma_pkg::SIZE_W'(sw)};
   end

   upgma_ram #(
      .WIDTH(upgma_pkg::DIST_WIDTH),
      .DEPTH(upgma_pkg::STORE_DEPTH)
   ) u_dist_ram (
      .clock  (clock),
      .wr_en  (dist_wr_en),
      .wr_addr(dist_wr_addr),
      .wr_data(dist_wr_data),
      .rd_addr(dist_rd_addr),
      .rd_data(dist_rd_data)
   );

   upgma_ram #(
      .WIDTH(upgma_pkg::NODE_DW),
      .DEPTH(upgma_pkg::NODE_SLOTS)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (node_wr_en),
      .wr_addr(w_ff),
      .wr_data(node_wr_data),
      .rd_addr(node_rd_addr),
      .rd_data(node_rd_data)
   );

   always_ff @(posedge clock) begin
      nidx_ff      <= node_rd_addr;
      pend_ff      <= 1'b0;
      rsp_valid_ff <= 1'b0;
      if (cand_better) begin
         found_ff <= 1'b1;
         best_ff  <= dist_rd_data;
         u_ff     <= pu_ff;
         v_ff     <= pv_ff;
      end
      if (csr_wr_en) begin
         taxa_ff <= csr_wr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_entry) begin
               n_ff     <= n_cfg;
               top_ff   <= top_cfg[upgma_pkg::NODE_W-1:0];
               w_ff     <= n_cfg;
               i_ff     <= '0;
               j_ff     <= upgma_pkg::NODE_W'(1);
               found_ff <= 1'b0;
               seen_ff  <= 1'b0;
               u_ff     <= '0;
               v_ff     <= upgma_pkg::NODE_W'(1);
               for (int x = 0; x < upgma_pkg::NODE_SLOTS; x++) begin
                  act_ff[x] <= (upgma_pkg::NODE_W'(x) < n_cfg);
               end
               state_ff <= (n_cfg == upgma_pkg::NODE_W'(2)) ? ST_FIN_SCAN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_ff <= act_ff[i_ff] && act_ff[j_ff];
            pu_ff   <= i_ff;
            pv_ff   <= j_ff;
            if ((j_ff + upgma_pkg::NODE_W'(1)) < w_ff) begin
               j_ff <= j_ff + upgma_pkg::NODE_W'(1);
            end else if ((i_ff + upgma_pkg::NODE_W'(2)) < w_ff) begin
               i_ff <= i_ff + upgma_pkg::NODE_W'(1);
               j_ff <= i_ff + upgma_pkg::NODE_W'(2);
            end else begin
               state_ff <= ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (found_ff || pend_ff) begin
               state_ff <= ST_RD_U;
            end else begin
               i_ff     <= '0;
               seen_ff  <= 1'b0;
               u_ff     <= '0;
               v_ff     <= upgma_pkg::NODE_W'(1);
               state_ff <= ST_FIN_SCAN;
            end
         end
         ST_RD_U: begin
            state_ff <= ST_RD_V;
         end
         ST_RD_V: begin
            hu_ff    <= node_h;
            su_ff    <= node_s;
            state_ff <= ST_RD_W;
         end
         ST_RD_W: begin
            hv_ff    <= node_h;
            sv_ff    <= node_s;
            k_ff     <= '0;
            state_ff <= ST_CHK;
         end
         ST_CHK: begin
            if (k_ff == w_ff) begin
               state_ff <= ST_COMMIT;
            end else if (!act_ff[k_ff] || (k_ff == u_ff) || (k_ff == v_ff)) begin
               k_ff <= k_ff + upgma_pkg::NODE_W'(1);
            end else begin
               state_ff <= ST_RDB;
            end
         end
         ST_RDB: begin
            acc_ff   <= product;
            state_ff <= ST_MULB;
         end
         ST_MULB: begin
            acc_ff     <= acc_ff + product;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
            state_ff   <= ST_DIV;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle shifted into the numerator.
            rem_ff     <= div_bit ? upgma_pkg::SUM_W'(div_r2 - {1'b0, sw})
                                  : div_r2[upgma_pkg::SUM_W-1:0];
            acc_ff     <= {acc_ff[upgma_pkg::NUM_W-2:0], div_bit};
            div_cnt_ff <= div_cnt_ff + upgma_pkg::DIV_CW'(1);
            if (div_cnt_ff == upgma_pkg::DIV_CW'(upgma_pkg::NUM_W - 1)) begin
               state_ff <= ST_WR;
            end
         end
         ST_WR: begin
            k_ff     <= k_ff + upgma_pkg::NODE_W'(1);
            state_ff <= ST_CHK;
         end
         ST_COMMIT: begin
            rsp_valid_ff  <= 1'b1;
            rsp_last_ff   <= 1'b0;
            rsp_left_ff   <= u_ff;
            rsp_right_ff  <= v_ff;
            rsp_parent_ff <= w_ff;
            rsp_lbr_ff    <= lbr;
            rsp_rbr_ff    <= rbr;
            act_ff[u_ff]  <= 1'b0;
            act_ff[v_ff]  <= 1'b0;
            act_ff[w_ff]  <= 1'b1;
            w_ff          <= w_ff + upgma_pkg::NODE_W'(1);
            i_ff          <= '0;
            j_ff          <= upgma_pkg::NODE_W'(1);
            found_ff      <= 1'b0;
            if ((w_ff + upgma_pkg::NODE_W'(1)) == top_ff) begin
               seen_ff  <= 1'b0;
               u_ff     <= '0;
               v_ff     <= upgma_pkg::NODE_W'(1);
               state_ff <= ST_FIN_SCAN;
            end else begin
               state_ff <= ST_SCAN;
            end
         end
         ST_FIN_SCAN: begin
            i_ff <= i_ff + upgma_pkg::NODE_W'(1);
            priority if (act_ff[i_ff] && seen_ff) begin
               v_ff     <= i_ff;
               state_ff <= ST_FIN_RD;
            end else if (act_ff[i_ff] && !seen_ff) begin
               u_ff    <= i_ff;
               seen_ff <= 1'b1;
               if (i_ff == top_ff - upgma_pkg::NODE_W'(1)) begin
                  state_ff <= ST_FIN_RD;
               end
            end else begin
               if (i_ff == top_ff - upgma_pkg::NODE_W'(1)) begin
                  state_ff <= ST_FIN_RD;
               end
            end
         end
         ST_FIN_RD: begin
            state_ff <= ST_FIN_RDV;
         end
         ST_FIN_RDV: begin
            best_ff  <= dist_rd_data;
            hu_ff    <= node_h;
            state_ff <= ST_FIN_EMIT;
         end
         ST_FIN_EMIT: begin
            rsp_valid_ff  <= 1'b1;
            rsp_last_ff   <= 1'b1;
            rsp_left_ff   <= u_ff;
            rsp_right_ff  <= v_ff;
            rsp_parent_ff <= top_ff;
            rsp_lbr_ff    <= lbr_fin;
            rsp_rbr_ff    <= rbr_fin;
            state_ff      <= ST_IDLE;
         end
         default: begin
            state_ff <= ST_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= ST_IDLE;
         taxa_ff      <= upgma_pkg::TAXA_W'(2);
         act_ff       <= '0;
         n_ff         <= upgma_pkg::NODE_W'(2);
         top_ff       <= upgma_pkg::NODE_W'(2);
         w_ff         <= upgma_pkg::NODE_W'(2);
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_last_merge   = rsp_last_ff;
   assign rsp_left_node    = rsp_left_ff;
   assign rsp_right_node   = rsp_right_ff;
   assign rsp_parent_node  = rsp_parent_ff;
   assign rsp_left_branch  = rsp_lbr_ff;
   assign rsp_right_branch = rsp_rbr_ff;

   // The root join ends the run: the engine is idle when it is reported.
   a_root_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_merge |-> !busy)
      else $error("root join reported while still busy");

   // Merge rounds never run past the last internal node.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> w_ff < top_ff)
      else $error("merge round beyond the root");

   // The flagged entry always starts a clustering run.
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_entry |=> busy)
      else $error("last entry did not start clustering");

   // Only the root join carries the root id.
   a_inner_parent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_merge |-> rsp_parent_node < top_ff)
      else $error("inner join carries the root id");

endmodule

### bench/tb_top.sv
// Self-checking testbench for upgma_cluster_engine: loads distance matrices, clusters them
// and compares every reported join with a built-in UPGMA predictor.
// Depends on upgma_pkg and the engine RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      upgma_pkg::node_type left_id;
      upgma_pkg::node_type right_id;
      upgma_pkg::node_type parent_id;
      upgma_pkg::dist_type left_len;
      upgma_pkg::dist_type right_len;
      logic                root_join;
   } join_rec_type;

   // Predicts the joins of each clustering run and checks the reported ones in order.
   class join_scoreboard;
      upgma_pkg::dist_type  pair_dist [upgma_pkg::STORE_DEPTH];
      bit                   is_active [upgma_pkg::NODE_SLOTS];
      int                   csize     [upgma_pkg::NODE_SLOTS];
      upgma_pkg::dist_type  height    [upgma_pkg::NODE_SLOTS];
      int                   taxa_reg;
      join_rec_type         pending_joins[$];
      int                   errors;

      function new();
         taxa_reg = 2;
         errors   = 0;
         foreach (height[i]) height[i] = '0;
         foreach (is_active[i]) is_active[i] = 0;
      endfunction

      function int slot_of(int a, int b);
         int lo, hi;
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         return hi * (hi - 1) / 2 + lo;
      endfunction

      function upgma_pkg::dist_type read_dist(int a, int b);
         if (a == b) return '0;
         return pair_dist[slot_of(a, b)];
      endfunction

      function upgma_pkg::dist_type avg_dist(upgma_pkg::dist_type a, upgma_pkg::dist_type b,
                                             int sa, int sb);
         logic [63:0] num;
         num = 64'(sa) * 64'(a) + 64'(sb) * 64'(b);
         return upgma_pkg::dist_type'(num / 64'(sa + sb));
      endfunction

      function upgma_pkg::dist_type clamp_len(upgma_pkg::dist_type hp,
                                              upgma_pkg::dist_type hc);
         return (hp > hc) ? hp - hc : '0;
      endfunction

      function int eff_taxa();
         if (taxa_reg < 2) return 2;
         if (taxa_reg > upgma_pkg::MAX_TAXA) return upgma_pkg::MAX_TAXA;
         return taxa_reg;
      endfunction

      function void set_taxa(int v);
         taxa_reg = v;
      endfunction

      function int pending();
         return pending_joins.size();
      endfunction

      // Notes one accepted transaction and predicts every join it triggers.
      function void note_entry(int row, int col, upgma_pkg::dist_type d, bit last);
         int n, top, u, v, seen;
         bit found;
         upgma_pkg::dist_type best, hw;
         join_rec_type jr;
         n   = eff_taxa();
         top = 2 * n - 2;
         if (row < col && col < n) pair_dist[slot_of(row, col)] = d;
         if (!last) return;
         for (int i = 0; i < upgma_pkg::NODE_SLOTS; i++) begin
            is_active[i] = (i < n);
            csize[i]     = (i < n) ? 1 : 0;
            if (i < n) height[i] = '0;
         end
         u = 0;
         v = 1;
         for (int w = n; w < top; w++) begin
            found = 0;
            best  = '0;
            for (int i = 0; i < w; i++) begin
               if (!is_active[i]) continue;
               for (int j = i + 1; j < w; j++) begin
                  if (!is_active[j]) continue;
                  if (!found || read_dist(i, j) < best) begin
                     found = 1;
                     best  = read_dist(i, j);
                     u     = i;
                     v     = j;
                  end
               end
            end
            if (!found) break;
            for (int k = 0; k < w; k++) begin
               if (!is_active[k] || k == u || k == v) continue;
               pair_dist[slot_of(k, w)] =
                  avg_dist(read_dist(u, k), read_dist(v, k), csize[u], csize[v]);
            end
            hw           = best >> 1;
            height[w]    = hw;
            csize[w]     = csize[u] + csize[v];
            is_active[u] = 0;
            is_active[v] = 0;
            is_active[w] = 1;
            jr = '{upgma_pkg::node_type'(u), upgma_pkg::node_type'(v),
                   upgma_pkg::node_type'(w),
                   clamp_len(hw, height[u]), clamp_len(hw, height[v]), 1'b0};
            pending_joins.push_back(jr);
         end
         seen = 0;
         u    = 0;
         v    = 1;
         for (int i = 0; i < top && seen < 2; i++) begin
            if (!is_active[i]) continue;
            if (seen == 0) u = i;
            else v = i;
            seen++;
         end
         hw = read_dist(u, v) >> 1;
         jr = '{upgma_pkg::node_type'(u), upgma_pkg::node_type'(v),
                upgma_pkg::node_type'(top),
                clamp_len(hw, height[u]), clamp_len(hw, height[v]), 1'b1};
         pending_joins.push_back(jr);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_join(join_rec_type got);
         join_rec_type exp;
         if (pending_joins.size() == 0) begin
            report($sformatf("unexpected join %0d+%0d->%0d",
                             got.left_id, got.right_id, got.parent_id));
            return;
         end
         exp = pending_joins.pop_front();
         if (got.left_id !== exp.left_id)
            report($sformatf("left_node %0d, want %0d", got.left_id, exp.left_id));
         if (got.right_id !== exp.right_id)
            report($sformatf("right_node %0d, want %0d", got.right_id, exp.right_id));
         if (got.parent_id !== exp.parent_id)
            report($sformatf("parent_node %0d, want %0d", got.parent_id, exp.parent_id));
         if (got.left_len !== exp.left_len)
            report($sformatf("left_branch %h, want %h", got.left_len, exp.left_len));
         if (got.right_len !== exp.right_len)
            report($sformatf("right_branch %h, want %h", got.right_len, exp.right_len));
         if (got.root_join !== exp.root_join)
            report($sformatf("last_merge %b, want %b", got.root_join, exp.root_join));
      endtask
   endclass

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [upgma_pkg::IDX_W-1:0]       req_row_index;
   logic [upgma_pkg::IDX_W-1:0]       req_col_index;
   logic [upgma_pkg::DIST_WIDTH-1:0]  req_distance;
   logic                              req_last_entry;
   logic                              csr_wr_en;
   logic [upgma_pkg::TAXA_W-1:0]      csr_wr_data;
   logic                              rsp_valid;
   logic [upgma_pkg::NODE_W-1:0]      rsp_left_node;
   logic [upgma_pkg::NODE_W-1:0]      rsp_right_node;
   logic [upgma_pkg::NODE_W-1:0]      rsp_parent_node;
   logic [upgma_pkg::DIST_WIDTH-1:0]  rsp_left_branch;
   logic [upgma_pkg::DIST_WIDTH-1:0]  rsp_right_branch;
   logic                              rsp_last_merge;

   join_scoreboard tree_sb;
   bit             leaf_loaded [upgma_pkg::MAX_TAXA][upgma_pkg::MAX_TAXA];
   int             entries_sent;
   bit             quiet_run;
   bit             set_gaps;
   int             dist_mode;

   upgma_cluster_engine dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_distance     (req_distance),
      .req_last_entry   (req_last_entry),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_left_node    (rsp_left_node),
      .rsp_right_node   (rsp_right_node),
      .rsp_parent_node  (rsp_parent_node),
      .rsp_left_branch  (rsp_left_branch),
      .rsp_right_branch (rsp_right_branch),
      .rsp_last_merge   (rsp_last_merge)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      join_rec_type got;
      if (!reset && rsp_valid) begin
         got = '{rsp_left_node, rsp_right_node, rsp_parent_node,
                 rsp_left_branch, rsp_right_branch, rsp_last_merge};
         tree_sb.check_join(got);
      end
   end

   function upgma_pkg::dist_type pick_dist();
      case (dist_mode)
         0: return upgma_pkg::dist_type'($urandom_range(0, 3));
         1: return upgma_pkg::dist_type'($urandom_range(0, 16'hFFFF));
         2: return upgma_pkg::dist_type'($urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00));
         default: return upgma_pkg::dist_type'($urandom());
      endcase
   endfunction

   // Offers one transaction and returns once it has been accepted.
   task send_entry(int row, int col, upgma_pkg::dist_type d, bit last);
      start          <= 1'b1;
      req_row_index  <= upgma_pkg::IDX_W'(row);
      req_col_index  <= upgma_pkg::IDX_W'(col);
      req_distance   <= d;
      req_last_entry <= last;
      do @(posedge clock); while (busy);
      tree_sb.note_entry(row, col, d, last);
      if (row < col && col < tree_sb.eff_taxa()) leaf_loaded[row][col] = 1;
      if (last) begin
         start <= 1'b0;
         @(posedge clock);
      end else if (!quiet_run && set_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Writes taxa_count once all joins of the previous run have been reported.
   task write_taxa(int v);
      start <= 1'b0;
      while (tree_sb.pending() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= upgma_pkg::TAXA_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tree_sb.set_taxa(v);
   endtask

   task send_noise();
      int row, col;
      row = $urandom_range(0, 31);
      col = (row == 31 || $urandom_range(0, 1)) ? $urandom_range(0, row)
                                                 : $urandom_range(tree_sb.eff_taxa(), 31);
      if (row < col && col < tree_sb.eff_taxa()) col = row;
      send_entry(row, col, upgma_pkg::dist_type'($urandom()), 0);
   endtask

   // Loads a matrix in shuffled order (skipping some entries that are already held),
   // sprinkles in dropped entries, and starts clustering with the final transaction.
   task cluster_set(bit partial, bit noisy, bit bad_last);
      int rows[$], cols[$], n, k, t;
      n = tree_sb.eff_taxa();
      for (int j = 1; j < n; j++)
         for (int i = 0; i < j; i++)
            if (!(partial && leaf_loaded[i][j] && $urandom_range(0, 2) != 0)) begin
               rows.push_back(i);
               cols.push_back(j);
            end
      for (int i = rows.size() - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = rows[i]; rows[i] = rows[k]; rows[k] = t;
         t = cols[i]; cols[i] = cols[k]; cols[k] = t;
      end
      if (rows.size() == 0) bad_last = 1;
      foreach (rows[i]) begin
         if (noisy && $urandom_range(0, 5) == 0) send_noise();
         send_entry(rows[i], cols[i], pick_dist(),
                    !bad_last && i == rows.size() - 1);
         entries_sent++;
      end
      if (bad_last) begin
         t = $urandom_range(0, 31);
         send_entry(t, $urandom_range(0, t), pick_dist(), 1);
      end
   endtask

   initial begin
      int n_pick;
      tree_sb        = new();
      entries_sent   = 0;
      quiet_run      = 0;
      set_gaps       = 1;
      reset          = 1'b1;
      start          = 1'b0;
      req_row_index  = '0;
      req_col_index  = '0;
      req_distance   = '0;
      req_last_entry = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: two taxa at the reset count with the largest distance, then a
      // rerun started by a dropped entry, all-equal distances, and all-zero distances.
      dist_mode = 2;
      send_entry(0, 1, 32'hFFFF_FFFF, 1);
      send_entry(1, 1, 32'h1234_5678, 1);
      write_taxa(3);
      send_entry(0, 1, 32'd5, 0);
      send_entry(0, 2, 32'd5, 0);
      send_entry(1, 2, 32'd5, 1);
      write_taxa(4);
      dist_mode = 0;
      for (int j = 1; j < 4; j++)
         for (int i = 0; i < j; i++)
            send_entry(i, j, '0, i == 2 && j == 3);
      send_entry(31, 0, 32'hFFFF_FFFF, 0);
      send_entry(3, 31, '0, 1);

      // Random sets, mostly small; counts below the legal range appear once, and one
      // larger set is loaded and then reloaded in part.
      for (int s = 0; entries_sent < 330; s++) begin
         if (s == 1) n_pick = 0;
         else if (s == 2) n_pick = 1;
         else if (s == 4 || s == 5) n_pick = 20;
         else if ($urandom_range(0, 3) != 0) n_pick = $urandom_range(2, 6);
         else n_pick = $urandom_range(7, 12);
         quiet_run = entries_sent > 280;
         set_gaps  = $urandom_range(0, 3) != 0;
         dist_mode = $urandom_range(0, 3);
         write_taxa(n_pick);
         cluster_set(s > 2 && $urandom_range(0, 2) == 0 || s == 5, $urandom_range(0, 1),
                     $urandom_range(0, 5) == 0);
      end

      start <= 1'b0;
      while (tree_sb.pending() != 0 || busy) @(posedge clock);
      repeat (200) @(posedge clock);
      if (tree_sb.pending() != 0)
         tree_sb.report($sformatf("%0d joins never reported", tree_sb.pending()));
      if (tree_sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
